@@ design/modbus_rtu_response_checker_unit_assert.svh @@
// assertion macros for the checker file
`ifndef MODBUS_RTU_RESPONSE_CHECKER_UNIT_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_UNIT_ASSERT_SVH

// clocked assertion, off during reset
`define MRC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define MRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	`MRC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

@@ design/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, constants and the byte-wide crc-16/modbus update for the reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);

	localparam logic [COUNT_W-1:0] MAX_PAYLOAD_C = COUNT_W'(MAX_PAYLOAD);
	localparam logic [COUNT_W-1:0] SUB_OFFSET    = COUNT_W'(3);

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

	localparam logic [2:0] PREFIX_BYTES_MAX = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
	localparam logic [2:0] ST_CRC_ERR    = 3'd2;
	localparam logic [2:0] ST_LEN_ERR    = 3'd3;
	localparam logic [2:0] ST_PREFIX_ERR = 3'd4;

	// register indexes
	localparam logic [1:0] CFG_EXPECTED_LENGTH = 2'd0;
	localparam logic [1:0] CFG_PREFIX_LENGTH   = 2'd1;
	localparam logic [1:0] CFG_EXPECTED_PREFIX = 2'd2;

	localparam logic [6:0]  RST_EXPECTED_LENGTH = 7'd5;
	localparam logic [2:0]  RST_PREFIX_LENGTH   = 3'd3;
	localparam logic [47:0] RST_EXPECTED_PREFIX = 48'h0103_0200_0000;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        tail_word;
		logic [15:0]        word_at_three;
		logic [COUNT_W-1:0] payload_count;
	} out_t;

	typedef struct packed {
		logic [6:0]  expected_length;
		logic [2:0]  prefix_length;
		logic [47:0] expected_prefix;
	} cfg_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] prefix_byte(input logic [47:0] p, input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = p[47:40];
			3'd1: r = p[39:32];
			3'd2: r = p[31:24];
			3'd3: r = p[23:16];
			3'd4: r = p[15:8];
			3'd5: r = p[7:0];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/modbus_rtu_response_checker_unit.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit
// Checks one Modbus RTU reply frame byte by byte: crc-16, length and prefix.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one frame byte per request, last_byte set on the final byte.
//   The final two bytes of a frame are the checksum, low byte first.
//   out channel: one request per frame, status plus tail word, the word at
//   payload offset three and the saturated payload count.
//   cfg channel: register index and data, always ready; write only while idle.
// Result path: a final byte is held in the input register, then its result
//   is held in the result register.
// Throughput: one byte per cycle unless a final byte is held back; the crc is updated a whole byte per cycle.
// Reset: registers return to their defaults, frame state is cleared, both
//   output and input registers are emptied.
// Stall: while a result waits, non-final bytes keep flowing; a final byte
//   waits in the input register until the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_checker_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  mrc_pkg::in_t      in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output mrc_pkg::out_t     out_data,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [47:0]  cfg_data
);
	import mrc_pkg::*;

	cfg_t cfg;
	logic item_valid_s1;
	in_t  item_s1;
	logic stall;
	logic step;
	logic result_valid;
	out_t result;
	logic out_full;

	mrc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// final byte held back while the result register is full and not being taken
	assign stall    = item_valid_s1 && item_s1.last_byte && out_full;
	assign step     = item_valid_s1 && !stall;
	assign in_ready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	mrc_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step         (step),
		.item         (item_s1),
		.result_valid (result_valid),
		.result       (result)
	);

	mrc_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (result_valid),
		.result     (result),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.full_stall (out_full)
	);

endmodule

`default_nettype wire

@@ design/mrc_cfg.sv @@
// ----------------------------------------------------------------------------
// mrc_cfg
// Configuration registers of the reply checker, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [47:0]  cfg_data,
	output mrc_pkg::cfg_t     cfg
);
	import mrc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_length <= RST_EXPECTED_LENGTH;
			cfg_q.prefix_length   <= RST_PREFIX_LENGTH;
			cfg_q.expected_prefix <= RST_EXPECTED_PREFIX;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_EXPECTED_LENGTH: cfg_q.expected_length <= cfg_data[6:0];
				CFG_PREFIX_LENGTH:   cfg_q.prefix_length   <= cfg_data[2:0];
				CFG_EXPECTED_PREFIX: cfg_q.expected_prefix <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/mrc_frame.sv @@
// ----------------------------------------------------------------------------
// mrc_frame
// Per-frame state: crc, held checksum bytes, count, prefix match and words.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_frame (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  mrc_pkg::cfg_t      cfg,
	input  wire logic          step,
	input  mrc_pkg::in_t       item,
	output logic               result_valid,
	output mrc_pkg::out_t      result
);
	import mrc_pkg::*;

	logic [15:0]        crc_q, crc_n;
	logic [7:0]         held0_q, held0_n, held1_q, held1_n;
	logic [1:0]         hv_q, hv_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic               pm_q, pm_n;
	logic [15:0]        tail_q, tail_n;
	logic [15:0]        sub_q, sub_n;
	logic               ovf_q, ovf_n;

	logic        take;
	logic [2:0]  plen;
	logic [15:0] rx_crc;
	logic [2:0]  status;

	always_comb begin
		crc_n   = crc_q;
		held0_n = held0_q;
		held1_n = held1_q;
		hv_n    = hv_q;
		count_n = count_q;
		pm_n    = pm_q;
		tail_n  = tail_q;
		sub_n   = sub_q;
		ovf_n   = ovf_q;
		take    = (hv_q == 2'd2);
		plen    = (cfg.prefix_length > PREFIX_BYTES_MAX) ? PREFIX_BYTES_MAX
			: cfg.prefix_length;

		if (take) begin
			crc_n  = crc16_byte(crc_q, held0_q);
			tail_n = {tail_q[7:0], held0_q};
			if (count_q >= MAX_PAYLOAD_C) begin
				ovf_n = 1'b1;
			end else begin
				if (count_q < COUNT_W'(plen)
					&& prefix_byte(cfg.expected_prefix, count_q[2:0]) != held0_q) begin
					pm_n = 1'b0;
				end
				if (count_q == SUB_OFFSET) begin
					sub_n = {held0_q, 8'h00};
				end else if (count_q == SUB_OFFSET + COUNT_W'(1)) begin
					sub_n = sub_q | {8'h00, held0_q};
				end
				count_n = count_q + COUNT_W'(1);
			end
			held0_n = held1_q;
			held1_n = item.rx_byte;
		end else if (hv_q == 2'd0) begin
			held0_n = item.rx_byte;
			hv_n    = 2'd1;
		end else begin
			held1_n = item.rx_byte;
			hv_n    = 2'd2;
		end

		// checksum arrives low byte first
		rx_crc = {item.rx_byte, take ? held1_q : held0_q};

		if (hv_q == 2'd0) begin
			status = ST_TOO_SHORT;
		end else if (rx_crc != crc_n) begin
			status = ST_CRC_ERR;
		end else if (ovf_n || count_n != cfg.expected_length) begin
			status = ST_LEN_ERR;
		end else if (!pm_n || count_n < COUNT_W'(plen)) begin
			status = ST_PREFIX_ERR;
		end else begin
			status = ST_OK;
		end
	end

	assign result_valid         = step && item.last_byte;
	assign result.status        = status;
	assign result.tail_word     = tail_n;
	assign result.word_at_three = sub_n;
	assign result.payload_count = count_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			held0_q <= 8'h00;
			held1_q <= 8'h00;
			hv_q    <= 2'd0;
			count_q <= '0;
			pm_q    <= 1'b1;
			tail_q  <= 16'h0000;
			sub_q   <= 16'h0000;
			ovf_q   <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				crc_q   <= CRC_INIT;
				held0_q <= 8'h00;
				held1_q <= 8'h00;
				hv_q    <= 2'd0;
				count_q <= '0;
				pm_q    <= 1'b1;
				tail_q  <= 16'h0000;
				sub_q   <= 16'h0000;
				ovf_q   <= 1'b0;
			end else begin
				crc_q   <= crc_n;
				held0_q <= held0_n;
				held1_q <= held1_n;
				hv_q    <= hv_n;
				count_q <= count_n;
				pm_q    <= pm_n;
				tail_q  <= tail_n;
				sub_q   <= sub_n;
				ovf_q   <= ovf_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/mrc_out_stage.sv @@
// ----------------------------------------------------------------------------
// mrc_out_stage
// Result register holding one reply status until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_out_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  mrc_pkg::out_t   result,
	output logic            out_valid,
	input  wire logic       out_ready,
	output mrc_pkg::out_t   out_data,
	output logic            full_stall
);
	import mrc_pkg::*;

	logic valid_q;
	out_t data_q;

	assign out_valid  = valid_q;
	assign out_data   = data_q;
	assign full_stall = valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

`default_nettype wire

@@ design/mrc_checker.sv @@
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks for the reply checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_response_checker_unit_assert.svh"

module mrc_checker (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input mrc_pkg::out_t  out_data
);
	import mrc_pkg::*;

	`MRC_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

	`MRC_ASSERT_IMPLY(a_short_empty, clk, arst_n, out_valid && out_data.status == ST_TOO_SHORT, out_data.payload_count == '0 && out_data.tail_word == 16'h0000 && out_data.word_at_three == 16'h0000, "too short frame with payload")

	`MRC_ASSERT_IMPLY(a_count_sat, clk, arst_n, out_valid, out_data.payload_count <= MAX_PAYLOAD_C, "payload count above saturation")

endmodule

bind modbus_rtu_response_checker_unit mrc_checker u_mrc_checker (.*);

`default_nettype wire

@@ bench/mrc_reply_monitor.sv @@
// ----------------------------------------------------------------------------
// mrc_reply_monitor
// Watches the byte, reply and register channels of the reply checker, runs
// its own crc-16/modbus frame model on every accepted byte and compares each
// reply request with the oldest predicted reply.
// ----------------------------------------------------------------------------

package modbus_bench_pkg;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = {crc[15:8], crc[7:0] ^ b};
		repeat (8) begin
			if (acc[0]) begin
				acc = {1'b0, acc[15:1]} ^ 16'hA001;
			end else begin
				acc = {1'b0, acc[15:1]};
			end
		end
		return acc;
	endfunction

endpackage

module mrc_reply_monitor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  mrc_pkg::in_t        in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  mrc_pkg::out_t       out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [47:0]         cfg_data,
	output int unsigned         mismatches,
	output int unsigned         replies_due
);
	import mrc_pkg::*;

	logic [6:0]  len_reg;
	logic [2:0]  plen_reg;
	logic [47:0] prefix_reg;

	logic [15:0] frame_crc;
	logic [7:0]  held [2];
	int unsigned held_n;
	int unsigned pay_cnt;
	logic        prefix_ok;
	logic [15:0] pay_tail;
	logic [15:0] word3;
	logic        overflow;

	out_t        reply_q [$];
	int unsigned bad;

	function automatic int unsigned prefix_span();
		return (plen_reg > PREFIX_BYTES_MAX) ? int'(PREFIX_BYTES_MAX) : int'(plen_reg);
	endfunction

	function automatic void clear_frame();
		frame_crc = CRC_INIT;
		held[0]   = 8'h00;
		held[1]   = 8'h00;
		held_n    = 0;
		pay_cnt   = 0;
		prefix_ok = 1'b1;
		pay_tail  = 16'h0000;
		word3     = 16'h0000;
		overflow  = 1'b0;
	endfunction

	function automatic void absorb_payload(input logic [7:0] b);
		logic [7:0] want;
		frame_crc = modbus_bench_pkg::crc16_step(frame_crc, b);
		pay_tail  = {pay_tail[7:0], b};
		if (pay_cnt >= MAX_PAYLOAD) begin
			overflow = 1'b1;
		end else begin
			if (pay_cnt < prefix_span()) begin
				want = 8'(prefix_reg >> (40 - 8 * pay_cnt));
				if (want != b) begin
					prefix_ok = 1'b0;
				end
			end
			if (pay_cnt == SUB_OFFSET) begin
				word3 = {b, 8'h00};
			end else if (pay_cnt == SUB_OFFSET + 1) begin
				word3[7:0] = b;
			end
			pay_cnt++;
		end
	endfunction

	function automatic void predict_byte(input in_t req);
		out_t want;
		if (held_n >= 2) begin
			absorb_payload(held[0]);
			held[0] = held[1];
			held[1] = req.rx_byte;
		end else begin
			held[held_n] = req.rx_byte;
			held_n++;
		end
		if (req.last_byte) begin
			if (held_n < 2) begin
				want.status = ST_TOO_SHORT;
			end else if ({held[1], held[0]} != frame_crc) begin
				want.status = ST_CRC_ERR;
			end else if (overflow || pay_cnt != len_reg) begin
				want.status = ST_LEN_ERR;
			end else if (!prefix_ok || pay_cnt < prefix_span()) begin
				want.status = ST_PREFIX_ERR;
			end else begin
				want.status = ST_OK;
			end
			want.tail_word     = pay_tail;
			want.word_at_three = word3;
			want.payload_count = COUNT_W'(pay_cnt);
			reply_q = {reply_q, want};
			clear_frame();
		end
	endfunction

	function automatic void compare_reply(input out_t got);
		out_t want;
		if (reply_q.size() == 0) begin
			bad++;
			if (bad <= 10) begin
				$display("unexpected reply: status %0d tail %h word3 %h count %0d",
					got.status, got.tail_word, got.word_at_three, got.payload_count);
			end
		end else begin
			want = reply_q.pop_front();
			if (got.status !== want.status || got.tail_word !== want.tail_word ||
					got.word_at_three !== want.word_at_three ||
					got.payload_count !== want.payload_count) begin
				bad++;
				if (bad <= 10) begin
					$display("reply mismatch: expected status %0d tail %h word3 %h count %0d",
						want.status, want.tail_word, want.word_at_three,
						want.payload_count);
					$display("                actual   status %0d tail %h word3 %h count %0d",
						got.status, got.tail_word, got.word_at_three, got.payload_count);
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg    = RST_EXPECTED_LENGTH;
			plen_reg   = RST_PREFIX_LENGTH;
			prefix_reg = RST_EXPECTED_PREFIX;
			clear_frame();
			reply_q.delete();
			bad = 0;
			mismatches  <= 0;
			replies_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_EXPECTED_LENGTH: len_reg    = cfg_data[6:0];
					CFG_PREFIX_LENGTH:   plen_reg   = cfg_data[2:0];
					CFG_EXPECTED_PREFIX: prefix_reg = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				compare_reply(out_data);
			end
			if (in_valid && in_ready) begin
				predict_byte(in_data);
			end
			mismatches  <= bad;
			replies_due <= reply_q.size();
		end
	end

endmodule

@@ bench/modbus_rtu_response_checker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit_tb
// Drives reply frames byte by byte into the checker: a few hand-built frames
// on the reset settings, then random frames, mostly well formed with a valid
// crc and matching prefix, under a series of register settings. Both sides
// stall at random; the monitor predicts and compares every reply.
// ----------------------------------------------------------------------------

module modbus_rtu_response_checker_unit_tb;
	import mrc_pkg::*;

	localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;
	localparam int         PHASES          = 12;
	localparam int         PHASE_BYTES     = 120;
	localparam int         IDLE_PCT        = 23;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	in_t         in_data   = '0;
	logic        out_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = CFG_EXPECTED_LENGTH;
	logic [47:0] cfg_data  = '0;
	logic        in_ready;
	logic        out_valid;
	out_t        out_data;
	logic        cfg_ready;

	int unsigned mismatches;
	int unsigned replies_due;

	logic        calm       = 1'b0;
	int unsigned bytes_sent = 0;
	logic [7:0]  frame [$];
	logic [6:0]  cur_len    = RST_EXPECTED_LENGTH;
	logic [2:0]  cur_plen   = RST_PREFIX_LENGTH;
	logic [47:0] cur_pre    = RST_EXPECTED_PREFIX;

	modbus_rtu_response_checker_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mrc_reply_monitor i_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.replies_due (replies_due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic push_byte(input logic [7:0] b, input logic lst);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{rx_byte: b, last_byte: lst};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame[i]) push_byte(frame[i], i == frame.size() - 1);
		frame.delete();
	endtask

	function automatic void seal_frame(input bit corrupt);
		logic [15:0] crc;
		crc = CRC_INIT;
		foreach (frame[i]) crc = modbus_bench_pkg::crc16_step(crc, frame[i]);
		if (corrupt) begin
			crc = crc ^ (16'h0001 << $urandom_range(15));
		end
		frame = {frame, crc[7:0], crc[15:8]};
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_due != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// mostly well formed frames; the rest noise, bad crc or a broken prefix
	task automatic random_frame();
		int unsigned kind;
		int unsigned n;
		int unsigned plen;
		int unsigned j;
		kind = $urandom_range(99);
		plen = (cur_plen > PREFIX_BYTES_MAX) ? int'(PREFIX_BYTES_MAX) : int'(cur_plen);
		if (kind >= 92 && kind < 96) begin
			n = $urandom_range(1, 4);
			repeat (n) frame = {frame, 8'($urandom)};
		end else begin
			if (kind < 60 && cur_len <= MAX_PAYLOAD) begin
				n = cur_len;
			end else if (kind < 96) begin
				n = $urandom_range(0, 12);
			end else begin
				n = $urandom_range(MAX_PAYLOAD - 2, MAX_PAYLOAD + 6);
			end
			for (int i = 0; i < n; i++) begin
				if (i < plen) begin
					frame = {frame, 8'(cur_pre >> (40 - 8 * i))};
				end else begin
					frame = {frame, 8'($urandom)};
				end
			end
			if (kind >= 85 && kind < 92 && plen > 0 && n > 0) begin
				j = $urandom_range(((n < plen) ? n : plen) - 1);
				frame[j] = frame[j] ^ (8'h01 << $urandom_range(7));
			end
			seal_frame(kind >= 75 && kind < 85);
		end
		send_frame();
	endtask

	initial begin
		logic [47:0] word;
		int unsigned phase_end;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames on the reset settings
		frame = '{8'hA5};
		send_frame();
		frame = '{8'hFF, 8'hFF};
		send_frame();
		frame = '{8'h01, 8'h03, 8'h02, 8'h00, 8'hFF};
		seal_frame(1'b0);
		send_frame();
		frame = '{8'h01, 8'h03, 8'h02, 8'h00, 8'hFF};
		seal_frame(1'b1);
		send_frame();
		frame = '{8'h01, 8'h04, 8'h02, 8'h12, 8'h34};
		seal_frame(1'b0);
		send_frame();

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			cur_pre = 48'({$urandom, $urandom});
			case (ph)
				0: begin
					cur_len  = 7'd64;
					cur_plen = 3'd6;
				end
				1: begin
					cur_len  = 7'd2;
					cur_plen = 3'd0;
					cur_pre  = '0;
				end
				2: begin
					cur_len  = 7'd0;
					cur_plen = 3'd7;
					cur_pre  = '1;
				end
				3: begin
					cur_len  = 7'd127;
					cur_plen = 3'd6;
				end
				4: begin
					cur_len  = 7'd1;
					cur_plen = 3'd1;
				end
				default: begin
					cur_len  = 7'($urandom_range(2, 12));
					cur_plen = 3'($urandom_range(0, 7));
				end
			endcase
			word = 48'({$urandom, $urandom});
			word[6:0] = cur_len;
			write_reg(CFG_EXPECTED_LENGTH, word);
			word = 48'({$urandom, $urandom});
			word[2:0] = cur_plen;
			write_reg(CFG_PREFIX_LENGTH, word);
			write_reg(CFG_EXPECTED_PREFIX, cur_pre);
			if (ph == 0 || $urandom_range(1) == 1) begin
				write_reg(CFG_SPARE_INDEX, 48'({$urandom, $urandom}));
			end
			calm = (ph == 6 || ph == 7);
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) random_frame();
		end

		settle();
		if (mismatches == 0 && replies_due == 0) begin
			$display("modbus_rtu_response_checker_unit regression: pass");
		end else begin
			$display("modbus_rtu_response_checker_unit regression: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("modbus_rtu_response_checker_unit regression: fail");
		$finish;
	end

endmodule
